[rtl/core/rcfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rcfd_pkg;

  localparam int CFG_W   = 13;
  localparam int PIX_W   = 8;
  localparam int CONF_W  = 16;
  localparam int REGIONS = 5;
  localparam int EDGES   = 20;
  localparam int EDGE_W  = 5;
  localparam int MILLI_W = 10;
  localparam int QB      = 19;   // confidence quotient bits before the cap

  localparam logic [CFG_W-1:0]  WIDTH_RESET  = 13'd1920;
  localparam logic [CFG_W-1:0]  HEIGHT_RESET = 13'd1080;
  localparam logic [CONF_W-1:0] Q_ONE        = 16'd32768;

  // floor(v/1000) == (v * RECIP) >> RECIP_SHIFT for v below 2^27
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;
  localparam int HALF_K = 500;

  localparam int CAST    = 0;
  localparam int HOOK    = 1;
  localparam int PANEL   = 2;
  localparam int HEADING = 3;
  localparam int BUTTONS = 4;

  localparam int CAST_NUM = 8;
  localparam int HOOK_NUM = 12;
  localparam int CONF_DEN = 100;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // edge e: region e/4, side e%4 = left, top, right, bottom
  function automatic logic [MILLI_W-1:0] edge_milli(input logic [EDGE_W-1:0] e);
    logic [MILLI_W-1:0] m;
    case (e)
      5'd0:  m = 10'd355;
      5'd1:  m = 10'd815;
      5'd2:  m = 10'd650;
      5'd3:  m = 10'd845;
      5'd4:  m = 10'd700;
      5'd5:  m = 10'd895;
      5'd6:  m = 10'd800;
      5'd7:  m = 10'd940;
      5'd8:  m = 10'd385;
      5'd9:  m = 10'd265;
      5'd10: m = 10'd615;
      5'd11: m = 10'd730;
      5'd12: m = 10'd395;
      5'd13: m = 10'd290;
      5'd14: m = 10'd585;
      5'd15: m = 10'd335;
      5'd16: m = 10'd400;
      5'd17: m = 10'd645;
      5'd18: m = 10'd600;
      5'd19: m = 10'd705;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] flag_num(input logic [2:0] k);
    logic [6:0] n;
    case (k)
      3'd0: n = 7'd8;
      3'd1: n = 7'd12;
      3'd2: n = 7'd72;
      3'd3: n = 7'd12;
      3'd4: n = 7'd58;
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [9:0] flag_den(input logic [2:0] k);
    logic [9:0] d;
    case (k)
      3'd2, 3'd4: d = 10'd100;
      default:    d = 10'd1000;
    endcase
    return d;
  endfunction

  // per-region colour tests, bit k for region k
  function automatic logic [REGIONS-1:0] color_hits(input logic [PIX_W-1:0] b,
                                                    input logic [PIX_W-1:0] g,
                                                    input logic [PIX_W-1:0] r);
    logic [REGIONS-1:0] h;
    logic [PIX_W:0] b9, g9, r9;
    b9 = {1'b0, b};
    g9 = {1'b0, g};
    r9 = {1'b0, r};
    h[CAST]    = (g >= 8'd85) && (g9 >= b9 + 9'd18) && (g9 >= r9 + 9'd18) &&
                 (r <= 8'd180);
    h[HOOK]    = (r >= 8'd145) && (r9 >= g9 + 9'd40) && (r9 >= b9 + 9'd35);
    h[PANEL]   = (b < 8'd55) && (g < 8'd55) && (r < 8'd55);
    h[HEADING] = (b > 8'd175) && (g > 8'd175) && (r > 8'd175);
    h[BUTTONS] = (b < 8'd75) && (g < 8'd75) && (r < 8'd75);
    return h;
  endfunction

endpackage
`default_nettype wire

[rtl/core/roi_color_fraction_detector_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Region color detector. Pixels stream in raster order, one beat per pixel;
// the counting stage takes the next pixel as it counts the held one, unless
// stalled. A frame start (start_of_frame, or the first pixel after a frame
// ends) first runs the region edge sequencer: a setup step, then a multiply and
// a divide state per region bound (20 bounds), while the first pixel holds the
// input. The last pixel's counts pass through a two-entry queue to the scoring
// unit, which runs areas, five fraction tests and two 19-step confidence
// divisions before the result beat appears; pixels of the next frame keep
// flowing meanwhile. Frame size registers take effect at the next frame start.
module roi_color_fraction_detector_unit
  import rcfd_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_enable,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [PIX_W-1:0]   blue,
  input  wire logic [PIX_W-1:0]   green,
  input  wire logic [PIX_W-1:0]   red,
  input  wire logic               start_of_frame,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    bar_ready,
  output logic [CONF_W-1:0]       bar_confidence,
  output logic                    red_hook,
  output logic [CONF_W-1:0]       red_hook_confidence,
  output logic                    panel_found
);

  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int POS_W = $clog2(MAX_DIMENSION);
  localparam int CNT_W = 2 * POS_W + 1;
  localparam int REC_W = REGIONS * (CNT_W + 2 * DIM_W);

  logic             f_valid, f_stall;
  logic [REC_W-1:0] f_data;
  logic             b_valid, b_stall;
  logic [REC_W-1:0] b_data;

  rcfd_front #(
    .MAX_DIMENSION(MAX_DIMENSION),
    .DIM_W(DIM_W),
    .POS_W(POS_W),
    .CNT_W(CNT_W),
    .REC_W(REC_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .blue(blue),
    .green(green),
    .red(red),
    .start_of_frame(start_of_frame),
    .rec_valid(f_valid),
    .rec_stall(f_stall),
    .rec_data(f_data)
  );

  rcfd_queue #(
    .W(REC_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .in_valid(f_valid),
    .in_stall(f_stall),
    .in_data(f_data),
    .out_valid(b_valid),
    .out_stall(b_stall),
    .out_data(b_data)
  );

  rcfd_back #(
    .DIM_W(DIM_W),
    .CNT_W(CNT_W),
    .REC_W(REC_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .rec_valid(b_valid),
    .rec_stall(b_stall),
    .rec_data(b_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .bar_ready(bar_ready),
    .bar_confidence(bar_confidence),
    .red_hook(red_hook),
    .red_hook_confidence(red_hook_confidence),
    .panel_found(panel_found)
  );

endmodule
`default_nettype wire

[rtl/core/rcfd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module rcfd_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [W-1:0]      out_data
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;
  logic         push;
  logic         pop;

  assign in_stall  = (fill == 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd2 && !pop |=> fill == 2'd2)
    else $error("queue lost a full entry");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("queue fill out of range");
  a_pop_order: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> fill == $past(fill) - 2'd1)
    else $error("queue fill did not drop on pop");
`endif

endmodule
`default_nettype wire

[rtl/core/rcfd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module rcfd_front
  import rcfd_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096,
  parameter int DIM_W = 13,
  parameter int POS_W = 12,
  parameter int CNT_W = 25,
  parameter int REC_W = 255
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_enable,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [PIX_W-1:0]   blue,
  input  wire logic [PIX_W-1:0]   green,
  input  wire logic [PIX_W-1:0]   red,
  input  wire logic               start_of_frame,
  output logic                    rec_valid,
  input  wire logic               rec_stall,
  output logic [REC_W-1:0]        rec_data
);

  localparam int EW = (CFG_W > DIM_W) ? CFG_W : DIM_W;
  localparam int PW = MILLI_W + DIM_W;
  localparam int MW = PW + 1 + RECIP_W;
  localparam int SLOT_W = CNT_W + 2 * DIM_W;

  typedef enum logic [2:0] {
    F_RUN = 3'b001,
    F_MUL = 3'b010,
    F_DIV = 3'b100
  } fstate_t;

  fstate_t state;
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [DIM_W-1:0] aw, ah;
  logic [DIM_W-1:0] eff_w, eff_h;
  logic [POS_W-1:0] col, row;
  logic             open;
  logic [DIM_W-1:0] bnd [REGIONS][4];
  logic [CNT_W-1:0] cnt [REGIONS];
  logic [CNT_W-1:0] cnt_next [REGIONS];
  logic [EDGE_W-1:0] edge_idx;
  logic [PW-1:0]    prod;

  logic             px_valid;
  logic [PIX_W-1:0] px_b, px_g, px_r;
  logic             px_sof;

  logic             need_start;
  logic             last;
  logic             proc;
  logic             accept;
  logic [REGIONS-1:0] hits;
  logic [REGIONS-1:0] roi_hit;
  logic [DIM_W-1:0] x_ext, y_ext;

  logic [2:0]       e_reg;
  logic [1:0]       e_side;
  logic [DIM_W-1:0] dim_sel;
  logic [PW:0]      v;
  logic [MW-1:0]    vq;
  logic [DIM_W-1:0] q, qc, qfix;
  logic [DIM_W-1:0] lo_edge;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] c);
    logic [EW-1:0] ce;
    logic [DIM_W-1:0] d;
    ce = EW'(c);
    if (c == '0) d = DIM_W'(1);
    else if (ce > EW'(MAX_DIMENSION)) d = DIM_W'(MAX_DIMENSION);
    else d = DIM_W'(c);
    return d;
  endfunction

  assign eff_w = eff_dim(frame_width);
  assign eff_h = eff_dim(frame_height);

  // region test and counting on the held pixel
  assign x_ext = DIM_W'(col);
  assign y_ext = DIM_W'(row);
  assign hits  = color_hits(px_b, px_g, px_r);

  always_comb begin
    for (int k = 0; k < REGIONS; k++) begin
      roi_hit[k]  = (x_ext >= bnd[k][0]) && (x_ext < bnd[k][2]) &&
                    (y_ext >= bnd[k][1]) && (y_ext < bnd[k][3]);
      cnt_next[k] = cnt[k] + CNT_W'(roi_hit[k] && hits[k]);
    end
  end

  assign need_start = px_sof || !open;
  assign last = (x_ext + DIM_W'(1) >= aw) && (y_ext + DIM_W'(1) >= ah);
  assign proc = px_valid && (state == F_RUN) && !need_start && (!last || !rec_stall);
  assign in_stall  = px_valid && !proc;
  assign accept    = in_valid && !in_stall;
  assign rec_valid = px_valid && (state == F_RUN) && !need_start && last;

  always_comb begin
    for (int k = 0; k < REGIONS; k++) begin
      rec_data[k*SLOT_W +: CNT_W] = cnt_next[k];
      rec_data[k*SLOT_W + CNT_W +: DIM_W] =
        (bnd[k][2] > bnd[k][0]) ? bnd[k][2] - bnd[k][0] : '0;
      rec_data[k*SLOT_W + CNT_W + DIM_W +: DIM_W] =
        (bnd[k][3] > bnd[k][1]) ? bnd[k][3] - bnd[k][1] : '0;
    end
  end

  // region edges: round(milli * size / 1000), then widen right/bottom edges
  assign e_reg   = edge_idx[4:2];
  assign e_side  = edge_idx[1:0];
  assign dim_sel = e_side[0] ? ah : aw;
  assign v       = (PW + 1)'(prod) + (PW + 1)'(HALF_K);
  assign vq      = MW'(v) * MW'(RECIP);
  assign q       = vq[RECIP_SHIFT +: DIM_W];
  assign qc      = (q < dim_sel) ? q : dim_sel;
  assign lo_edge = bnd[e_reg][{1'b0, e_side[0]}];

  always_comb begin
    qfix = qc;
    if (e_side[1] && (lo_edge < dim_sel) && (qc < lo_edge + DIM_W'(1))) begin
      qfix = lo_edge + DIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_b <= blue;
      px_g <= green;
      px_r <= red;
    end
    if (state == F_MUL) begin
      prod <= PW'(edge_milli(edge_idx)) * PW'(dim_sel);
    end
    if (state == F_DIV) begin
      bnd[e_reg][e_side] <= qfix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_RUN;
      px_valid <= 1'b0;
      px_sof   <= 1'b0;
      open     <= 1'b0;
      col      <= '0;
      row      <= '0;
      aw       <= '0;
      ah       <= '0;
      edge_idx <= '0;
      for (int k = 0; k < REGIONS; k++) cnt[k] <= '0;
    end else begin
      if (accept) begin
        px_valid <= 1'b1;
        px_sof   <= start_of_frame;
      end else if (proc) begin
        px_valid <= 1'b0;
      end
      unique case (state)
        F_RUN: begin
          if (px_valid && need_start) begin
            aw       <= eff_w;
            ah       <= eff_h;
            open     <= 1'b1;
            px_sof   <= 1'b0;
            col      <= '0;
            row      <= '0;
            edge_idx <= '0;
            for (int k = 0; k < REGIONS; k++) cnt[k] <= '0;
            state    <= F_MUL;
          end else if (proc) begin
            for (int k = 0; k < REGIONS; k++) cnt[k] <= cnt_next[k];
            if (last) begin
              open <= 1'b0;
              col  <= '0;
              row  <= '0;
            end else if (x_ext + DIM_W'(1) >= aw) begin
              col <= '0;
              row <= row + POS_W'(1);
            end else begin
              col <= col + POS_W'(1);
            end
          end
        end
        F_MUL: state <= F_DIV;
        F_DIV: begin
          if (edge_idx == EDGE_W'(EDGES - 1)) begin
            state <= F_RUN;
          end else begin
            edge_idx <= edge_idx + EDGE_W'(1);
            state    <= F_MUL;
          end
        end
        default: state <= F_RUN;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_push_last: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_stall |=> !open)
    else $error("frame still open after result beat");
  a_no_proc_in_bounds: assert property (@(posedge clk) disable iff (rst)
    state != F_RUN |-> !proc)
    else $error("pixel processed while bounds are computed");
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    open && state == F_RUN |-> x_ext < aw && y_ext < ah)
    else $error("position outside frame");
`endif

endmodule
`default_nettype wire

[rtl/core/rcfd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module rcfd_back
  import rcfd_pkg::*;
#(
  parameter int DIM_W = 13,
  parameter int CNT_W = 25,
  parameter int REC_W = 255
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rec_valid,
  output logic                    rec_stall,
  input  wire logic [REC_W-1:0]   rec_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    bar_ready,
  output logic [CONF_W-1:0]       bar_confidence,
  output logic                    red_hook,
  output logic [CONF_W-1:0]       red_hook_confidence,
  output logic                    panel_found
);

  localparam int SLOT_W = CNT_W + 2 * DIM_W;
  localparam int NW = CNT_W + 24;
  localparam int FW = CNT_W + 10;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_AREA  = 6'b000010,
    B_CMP   = 6'b000100,
    B_SETUP = 6'b001000,
    B_DIV   = 6'b010000,
    B_OUT   = 6'b100000
  } bstate_t;

  bstate_t state;
  logic [CNT_W-1:0] cnt  [REGIONS];
  logic [DIM_W-1:0] wd   [REGIONS];
  logic [DIM_W-1:0] ht   [REGIONS];
  logic [CNT_W-1:0] area [REGIONS];
  logic [REGIONS-1:0] pass;
  logic [2:0]       k;
  logic             which;
  logic [NW-1:0]    rem;
  logic [NW-1:0]    dsh;
  logic [QB-1:0]    quo;
  logic [4:0]       bit_idx;
  logic [CONF_W-1:0] conf [2];

  logic [FW-1:0]    lhs, rhs;
  logic [CNT_W-1:0] sel_cnt, sel_area;
  logic [3:0]       sel_num;
  logic             take;
  logic             ge;
  logic [QB-1:0]    quo_next;
  logic [CONF_W-1:0] capped;

  assign rec_stall = (state != B_IDLE);
  assign take      = out_valid && !out_stall;

  // fraction test: count * den >= num * area
  assign lhs = FW'(cnt[k]) * FW'(flag_den(k));
  assign rhs = FW'(area[k]) * FW'(flag_num(k));

  assign sel_cnt  = which ? cnt[HOOK] : cnt[CAST];
  assign sel_area = which ? area[HOOK] : area[CAST];
  assign sel_num  = which ? 4'(HOOK_NUM) : 4'(CAST_NUM);

  // one quotient bit per cycle, divisor pre-shifted and walked down
  assign ge       = (rem >= dsh);
  assign quo_next = {quo[QB-2:0], ge};
  assign capped   = (sel_area == '0) ? '0 :
                    (quo_next > QB'(Q_ONE)) ? Q_ONE : CONF_W'(quo_next);

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        for (int i = 0; i < REGIONS; i++) begin
          cnt[i] <= rec_data[i*SLOT_W +: CNT_W];
          wd[i]  <= rec_data[i*SLOT_W + CNT_W +: DIM_W];
          ht[i]  <= rec_data[i*SLOT_W + CNT_W + DIM_W +: DIM_W];
        end
      end
      B_AREA: area[k] <= CNT_W'(wd[k]) * CNT_W'(ht[k]);
      B_CMP: pass[k] <= (area[k] != '0) && (lhs >= rhs);
      B_SETUP: begin
        rem <= (NW'(sel_cnt) * NW'(CONF_DEN) << 16) + NW'(sel_area) * NW'(sel_num);
        dsh <= (NW'(sel_area) * NW'(sel_num) << 1) << (QB - 1);
        quo <= '0;
      end
      B_DIV: begin
        if (ge) rem <= rem - dsh;
        dsh <= dsh >> 1;
        quo <= quo_next;
        if (bit_idx == '0) conf[which] <= capped;
      end
      B_OUT: begin
        if (!out_valid || take) begin
          bar_ready           <= pass[CAST];
          bar_confidence      <= conf[0];
          red_hook            <= pass[HOOK];
          red_hook_confidence <= pass[HOOK] ? conf[1] : '0;
          panel_found         <= pass[PANEL] && pass[HEADING] && pass[BUTTONS];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
      which     <= 1'b0;
      bit_idx   <= '0;
    end else begin
      if (take && state != B_OUT) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (rec_valid) begin
            k     <= '0;
            state <= B_AREA;
          end
        end
        B_AREA: begin
          if (k == 3'(REGIONS - 1)) begin
            k     <= '0;
            state <= B_CMP;
          end else begin
            k <= k + 3'd1;
          end
        end
        B_CMP: begin
          if (k == 3'(REGIONS - 1)) begin
            which <= 1'b0;
            state <= B_SETUP;
          end else begin
            k <= k + 3'd1;
          end
        end
        B_SETUP: begin
          bit_idx <= 5'(QB - 1);
          state   <= B_DIV;
        end
        B_DIV: begin
          if (bit_idx == '0) begin
            if (which) begin
              state <= B_OUT;
            end else begin
              which <= 1'b1;
              state <= B_SETUP;
            end
          end else begin
            bit_idx <= bit_idx - 5'd1;
          end
        end
        B_OUT: begin
          if (!out_valid || take) begin
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hook_conf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !red_hook |-> red_hook_confidence == '0)
    else $error("hook confidence without hook");
  a_conf_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bar_confidence <= Q_ONE && red_hook_confidence <= Q_ONE)
    else $error("confidence above one");
  a_bar_conf_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && bar_ready |-> bar_confidence >= 16'd3277)
    else $error("bar ready with low confidence");
  a_hook_conf_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && red_hook |-> red_hook_confidence >= 16'd3277)
    else $error("red hook with low confidence");
`endif

endmodule
`default_nettype wire
